// ----- design/slc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the split L1 tag and replacement controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package slc_pkg;

  localparam int OFF_W   = 6;
  localparam int SET_W   = 14;
  localparam int ADDR_W  = 32;
  localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
  localparam int DWAYS   = 4;
  localparam int IWAYS   = 2;
  localparam int DWAY_W  = $clog2(DWAYS);
  localparam int IWAY_W  = $clog2(IWAYS);
  localparam int AGE_W   = $clog2(DWAYS + 1);
  localparam int NSETS   = 1 << SET_W;
  localparam int CNT_W   = 32;
  localparam int CNT_NUM = 7;

  typedef logic [2:0] action_t;
  localparam action_t ACT_DREAD  = 3'd0;
  localparam action_t ACT_DWRITE = 3'd1;
  localparam action_t ACT_IFETCH = 3'd2;
  localparam action_t ACT_INVAL  = 3'd3;
  localparam action_t ACT_CLEAR  = 3'd4;

  typedef logic [1:0] lstate_t;
  localparam lstate_t LS_I = 2'd0;
  localparam lstate_t LS_V = 2'd1;
  localparam lstate_t LS_M = 2'd2;

  typedef logic [1:0] l2msg_t;
  localparam l2msg_t L2_NONE   = 2'd0;
  localparam l2msg_t L2_READ   = 2'd1;
  localparam l2msg_t L2_RFO_WT = 2'd2;
  localparam l2msg_t L2_RFO_WB = 2'd3;

  localparam int CNT_DREAD  = 0;
  localparam int CNT_DWRITE = 1;
  localparam int CNT_DHIT   = 2;
  localparam int CNT_DMISS  = 3;
  localparam int CNT_IREAD  = 4;
  localparam int CNT_IHIT   = 5;
  localparam int CNT_IMISS  = 6;

  typedef struct packed {
    logic [DWAYS-1:0][TAG_W-1:0] tag;
    logic [DWAYS-1:0][AGE_W-1:0] age;
    logic [DWAYS-1:0][1:0]       st;
  } drow_t;

  typedef struct packed {
    logic [IWAYS-1:0][TAG_W-1:0] tag;
    logic [IWAYS-1:0]            age;
    logic [IWAYS-1:0]            vld;
  } irow_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic clear_req;
  } status_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOK
  } fsm_t;

endpackage

// ----- design/slc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: accepts requests, sequences lookup and update,
// and runs the store clearing sweep. Depends on slc_pkg.
module slc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  slc_pkg::status_t sts,
  output slc_pkg::cmd_t    cmd
);
  import slc_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.update = 1'b1;
        state_nxt  = sts.clear_req ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/slc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: set memories for both caches, hit and victim selection, age
// update, usage counters and result registers. Depends on slc_pkg.
module slc_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  slc_pkg::cmd_t           cmd,
  output slc_pkg::status_t        sts,
  input  logic [2:0]              in_action,
  input  logic [31:0]             in_address,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [1:0]              out_way_used,
  output logic [1:0]              out_l2_message,
  output logic [31:0]             out_data_reads,
  output logic [31:0]             out_data_writes,
  output logic [31:0]             out_data_hits,
  output logic [31:0]             out_data_misses,
  output logic [31:0]             out_inst_reads,
  output logic [31:0]             out_inst_hits,
  output logic [31:0]             out_inst_misses
);
  import slc_pkg::*;

  drow_t dmem [NSETS];
  irow_t imem [NSETS];

  drow_t             drow_r, drow_new;
  irow_t             irow_r, irow_new;
  action_t           action_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SET_W-1:0]  set_r;
  logic [SET_W-1:0]  sweep_r;
  logic [SET_W-1:0]  waddr;
  logic [CNT_W-1:0]  cnt_r [CNT_NUM];
  logic [CNT_W-1:0]  cnt_nxt [CNT_NUM];
  logic              valid_r;
  logic              hit_r, hit_nxt;
  logic [1:0]        way_r, way_nxt;
  l2msg_t            l2_r, l2_nxt;

  // Lookup, victim choice and age update on the row read for this request.
  always_comb begin
    logic [DWAYS-1:0]  dhv;
    logic              dhit, dempty, done;
    logic [DWAY_W-1:0] dhw, dew, d1w, dmw, dw;
    logic [IWAYS-1:0]  ihv;
    logic              ihit, iempty, izero;
    logic [IWAY_W-1:0] ihw, iew, izw, iw;
    logic              wr;
    dhv = '0; dhit = 1'b0; dempty = 1'b0; done = 1'b0;
    dhw = '0; dew = '0; d1w = '0; dmw = '0;
    ihv = '0; ihit = 1'b0; iempty = 1'b0; izero = 1'b0;
    ihw = '0; iew = '0; izw = '0;
    wr = (action_r == ACT_DWRITE);
    drow_new = drow_r;
    irow_new = irow_r;
    for (int i = DWAYS - 1; i >= 0; i--) begin
      dhv[i] = (drow_r.st[i] != LS_I) && (drow_r.tag[i] == tag_r);
      if (dhv[i]) begin
        dhit = 1'b1;
        dhw  = DWAY_W'(i);
      end
      if (drow_r.st[i] == LS_I) begin
        dempty = 1'b1;
        dew    = DWAY_W'(i);
      end
      if (drow_r.age[i] == AGE_W'(1)) begin
        done = 1'b1;
        d1w  = DWAY_W'(i);
      end
    end
    for (int i = 1; i < DWAYS; i++) begin
      if (drow_r.age[i] < drow_r.age[dmw]) begin
        dmw = DWAY_W'(i);
      end
    end
    dw = dhit ? dhw : (dempty ? dew : (done ? d1w : dmw));
    for (int i = IWAYS - 1; i >= 0; i--) begin
      ihv[i] = irow_r.vld[i] && (irow_r.tag[i] == tag_r);
      if (ihv[i]) begin
        ihit = 1'b1;
        ihw  = IWAY_W'(i);
      end
      if (!irow_r.vld[i]) begin
        iempty = 1'b1;
        iew    = IWAY_W'(i);
      end
      if (!irow_r.age[i]) begin
        izero = 1'b1;
        izw   = IWAY_W'(i);
      end
    end
    iw = ihit ? ihw : (iempty ? iew : (izero ? izw : '0));

    hit_nxt = 1'b0;
    way_nxt = '0;
    l2_nxt  = L2_NONE;
    for (int k = 0; k < CNT_NUM; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end

    case (action_r)
      ACT_DREAD, ACT_DWRITE: begin
        if (wr) cnt_nxt[CNT_DWRITE] = cnt_r[CNT_DWRITE] + 1'b1;
        else    cnt_nxt[CNT_DREAD]  = cnt_r[CNT_DREAD] + 1'b1;
        hit_nxt = dhit;
        way_nxt = 2'(dw);
        if (dhit) begin
          cnt_nxt[CNT_DHIT] = cnt_r[CNT_DHIT] + 1'b1;
          if (wr) drow_new.st[dw] = LS_M;
        end else begin
          cnt_nxt[CNT_DMISS] = cnt_r[CNT_DMISS] + 1'b1;
          drow_new.tag[dw] = tag_r;
          if (dempty) begin
            drow_new.st[dw] = LS_V;
            l2_nxt = wr ? L2_RFO_WT : L2_READ;
          end else begin
            drow_new.st[dw] = wr ? LS_M : LS_V;
            l2_nxt = wr ? L2_RFO_WB : L2_READ;
          end
        end
        for (int i = 0; i < DWAYS; i++) begin
          if (DWAY_W'(i) != dw && drow_r.age[i] > drow_r.age[dw]) begin
            drow_new.age[i] = drow_r.age[i] - 1'b1;
          end
        end
        drow_new.age[dw] = AGE_W'(DWAYS);
      end
      ACT_IFETCH: begin
        cnt_nxt[CNT_IREAD] = cnt_r[CNT_IREAD] + 1'b1;
        hit_nxt = ihit;
        way_nxt = 2'(iw);
        if (ihit) begin
          cnt_nxt[CNT_IHIT] = cnt_r[CNT_IHIT] + 1'b1;
        end else begin
          cnt_nxt[CNT_IMISS] = cnt_r[CNT_IMISS] + 1'b1;
          irow_new.vld[iw] = 1'b1;
          irow_new.tag[iw] = tag_r;
          l2_nxt = L2_READ;
        end
        for (int i = 0; i < IWAYS; i++) begin
          if (IWAY_W'(i) != iw && irow_r.age[i] > irow_r.age[iw]) begin
            irow_new.age[i] = 1'b0;
          end
        end
        irow_new.age[iw] = 1'b1;
      end
      ACT_INVAL: begin
        hit_nxt = dhit;
        way_nxt = dhit ? 2'(dhw) : 2'd0;
        for (int i = 0; i < DWAYS; i++) begin
          if (dhv[i]) drow_new.st[i] = LS_I;
        end
      end
      ACT_CLEAR: begin
        for (int k = 0; k < CNT_NUM; k++) begin
          cnt_nxt[k] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign waddr = cmd.sweep ? sweep_r : set_r;

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      dmem[waddr] <= '0;
      imem[waddr] <= '0;
    end else if (cmd.update) begin
      dmem[waddr] <= drow_new;
      imem[waddr] <= irow_new;
    end
    if (cmd.accept) begin
      drow_r   <= dmem[in_address[OFF_W +: SET_W]];
      irow_r   <= imem[in_address[OFF_W +: SET_W]];
      action_r <= in_action;
      tag_r    <= in_address[ADDR_W-1 -: TAG_W];
      set_r    <= in_address[OFF_W +: SET_W];
    end
    if (cmd.update) begin
      hit_r <= hit_nxt;
      way_r <= way_nxt;
      l2_r  <= l2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      valid_r <= 1'b0;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      valid_r <= cmd.update;
      if (cmd.sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.update) begin
        for (int k = 0; k < CNT_NUM; k++) begin
          cnt_r[k] <= cnt_nxt[k];
        end
      end
    end
  end

  assign sts.sweep_last = (sweep_r == {SET_W{1'b1}});
  assign sts.clear_req  = (action_r == ACT_CLEAR);

  assign out_valid       = valid_r;
  assign out_hit         = hit_r;
  assign out_way_used    = way_r;
  assign out_l2_message  = l2_r;
  assign out_data_reads  = cnt_r[CNT_DREAD];
  assign out_data_writes = cnt_r[CNT_DWRITE];
  assign out_data_hits   = cnt_r[CNT_DHIT];
  assign out_data_misses = cnt_r[CNT_DMISS];
  assign out_inst_reads  = cnt_r[CNT_IREAD];
  assign out_inst_hits   = cnt_r[CNT_IHIT];
  assign out_inst_misses = cnt_r[CNT_IMISS];

endmodule

// ----- design/split_l1_cache_tag_lru_controller_unit.sv -----
`timescale 1ns / 1ps
// Top level of the split L1 tag and replacement controller.
// Depends on slc_pkg, slc_ctrl and slc_datapath.
//
// Usage: a request (in_action, in_address) is taken at a rising edge where
// start is high and busy is low. Actions are data read, data write,
// instruction fetch, invalidate data line and clear all.
// Every request produces exactly one result, shown for one cycle with
// out_valid high: hit, way, L2 message and the seven usage counters.
// Latency: the set row is read at the accepting edge, updated and written
// back at the next edge, and out_valid is high in the cycle after that.
// No new request is taken before the previous row is written back. A new
// request can be taken in the cycle that shows the previous result, unless
// that request was a clear all, which starts a sweep. Reset and the clear
// action run a sweep over all 16384 sets, one row per cycle, holding busy
// high throughout. Counters wrap modulo 2^32.
// The receiver has no stall signal; results must be captured when shown.
module split_l1_cache_tag_lru_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_address,
  output logic        out_valid,
  output logic        out_hit,
  output logic [1:0]  out_way_used,
  output logic [1:0]  out_l2_message,
  output logic [31:0] out_data_reads,
  output logic [31:0] out_data_writes,
  output logic [31:0] out_data_hits,
  output logic [31:0] out_data_misses,
  output logic [31:0] out_inst_reads,
  output logic [31:0] out_inst_hits,
  output logic [31:0] out_inst_misses
);
  import slc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  slc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  slc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_way_used    (out_way_used),
    .out_l2_message  (out_l2_message),
    .out_data_reads  (out_data_reads),
    .out_data_writes (out_data_writes),
    .out_data_hits   (out_data_hits),
    .out_data_misses (out_data_misses),
    .out_inst_reads  (out_inst_reads),
    .out_inst_hits   (out_inst_hits),
    .out_inst_misses (out_inst_misses)
  );

endmodule

// ----- design/slc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the split L1 tag controller, bound to the top level.
// Depends on slc_pkg and the top level's ports.
module slc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_hit,
  input logic [1:0] out_l2_message
);
  import slc_pkg::*;

  // Every accepted request yields its result, with out_valid high.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request produced no result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("controller not busy after accepting a request");

  // A hit never needs traffic to L2.
  a_hit_l2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_l2_message == L2_NONE))
    else $error("hit reported with an L2 message");

endmodule

bind split_l1_cache_tag_lru_controller_unit slc_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_l2_message (out_l2_message)
);
